// ----- hw/rtl/selective_repeat_receive_window_assert.svh -----
// assertion macros for the receive window
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define SRRW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("label failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SRRW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("label failed");
`endif

// ----- hw/rtl/srrw_pkg.sv -----
// shared constants and types for the receive window
package srrw_pkg;
    localparam int WINDOW_MAX = 32;
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int WIN_W = $clog2(WINDOW_MAX + 1);
    localparam logic [9:0] TEXT_LIMIT = 10'd256;
    localparam logic [9:0] HASH_LIMIT = 10'd128;
    localparam logic [9:0] OFFSET_BYTES = 10'd4;

    localparam logic [2:0] OP_NAME = 3'd0;
    localparam logic [2:0] OP_WINDOW = 3'd1;
    localparam logic [2:0] OP_FSIZE = 3'd2;
    localparam logic [2:0] OP_HASH = 3'd3;
    localparam logic [2:0] OP_START = 3'd4;
    localparam logic [2:0] OP_DATA = 3'd5;
    localparam logic [2:0] OP_STOP = 3'd6;

    localparam logic [1:0] K_ACK = 2'd0;
    localparam logic [1:0] K_NACK = 2'd1;
    localparam logic [1:0] K_DELIVER = 2'd2;

    // request to the modulo unit and its answer
    typedef struct packed {
        logic start;
        logic [31:0] dividend;
        logic [WIN_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic done;
        logic [SLOT_W-1:0] rem;
    } mod_rsp_t;
endpackage

// ----- hw/rtl/selective_repeat_receive_window.sv -----
// selective-repeat receive window: ack/nack decisions and in-order drain
// an answer word is valid in the cycle after acceptance; in-window data first gets its slot index
// from the shared 32-step serial remainder unit, is then stored, and every slot check of the drain
// goes through the same unit; a new packet is taken only in idle, with no answer word still pending
// reset: asynchronous active low; clears sequence state, flags and slot valid bits
module selective_repeat_receive_window (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [2:0] opcode,
    input  logic [31:0] seq_num,
    input  logic crc_ok,
    input  logic [9:0] body_len,
    input  logic [15:0] window_request,
    input  logic [7:0] buffer_handle,
    output logic out_valid,
    input  logic out_stall,
    output logic [1:0] kind,
    output logic [31:0] ack_seq,
    output logic [7:0] out_handle,
    output logic [9:0] out_len,
    output logic last
);
    localparam int SW = srrw_pkg::SLOT_W;
    localparam int WW = srrw_pkg::WIN_W;

    typedef enum logic [2:0] {
        S_IDLE, S_IDX, S_STORE, S_DIDX, S_DCHK, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] exp_reg;
    logic [WW-1:0] win_reg;
    logic started_reg, open_reg, fin_reg;
    logic [srrw_pkg::WINDOW_MAX-1:0] valid_reg;
    // slot store, read through a registered port
    logic [31:0] mseq [srrw_pkg::WINDOW_MAX];
    logic [9:0] mlen [srrw_pkg::WINDOW_MAX];
    logic [7:0] mhdl [srrw_pkg::WINDOW_MAX];
    logic [31:0] rd_seq_reg;
    logic [9:0] rd_len_reg;
    logic [7:0] rd_hdl_reg;
    logic [SW-1:0] idx_reg;
    // captured packet
    logic [31:0] pseq_reg;
    logic [9:0] plen_reg;
    logic [7:0] phdl_reg;
    // output word
    logic ov_reg;
    logic [1:0] kind_reg;
    logic [31:0] aseq_reg;
    logic [7:0] ohdl_reg;
    logic [9:0] olen_reg;
    logic last_reg;
    // after the word is taken: drain or go idle
    logic drain_reg;

    srrw_pkg::mod_req_t mreq;
    srrw_pkg::mod_rsp_t mrsp;

    srrw_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    logic accept;
    logic taken;
    logic len_txt_bad;
    logic [32:0] win_top;
    logic in_win;
    logic hit;
    logic deliver;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign taken = ov_reg && !out_stall;
    assign len_txt_bad = (body_len == 10'd0) || (body_len >= srrw_pkg::TEXT_LIMIT);
    assign win_top = {1'b0, exp_reg} + {{(33-WW){1'b0}}, win_reg};
    assign in_win = (seq_num >= exp_reg) && ({1'b0, seq_num} < win_top);
    assign hit = valid_reg[idx_reg] && (rd_seq_reg == exp_reg);
    assign deliver = (rd_len_reg > srrw_pkg::OFFSET_BYTES) && open_reg;

    always_comb
    begin
        mreq.start = 1'b0;
        mreq.dividend = exp_reg;
        mreq.divisor = win_reg;
        if (state_reg == S_IDLE)
        begin
            mreq.dividend = seq_num;
            mreq.start = accept && !fin_reg && crc_ok && opcode == srrw_pkg::OP_DATA
                && started_reg && win_reg != '0
                && body_len >= srrw_pkg::OFFSET_BYTES && in_win;
        end
        else if (state_reg == S_STORE)
            // first drain check starts right after the store
            mreq.start = 1'b1;
        else if (state_reg == S_OUT)
            mreq.start = (!ov_reg || taken) && drain_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_STORE && !valid_reg[idx_reg])
        begin
            mseq[idx_reg] <= pseq_reg;
            mlen[idx_reg] <= plen_reg;
            mhdl[idx_reg] <= phdl_reg;
        end
        rd_seq_reg <= mseq[mrsp.rem];
        rd_len_reg <= mlen[mrsp.rem];
        rd_hdl_reg <= mhdl[mrsp.rem];
        if (accept)
        begin
            pseq_reg <= seq_num;
            plen_reg <= body_len;
            phdl_reg <= buffer_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            exp_reg <= '0;
            win_reg <= '0;
            started_reg <= 1'b0;
            open_reg <= 1'b0;
            fin_reg <= 1'b0;
            valid_reg <= '0;
            idx_reg <= '0;
            ov_reg <= 1'b0;
            kind_reg <= srrw_pkg::K_ACK;
            aseq_reg <= '0;
            ohdl_reg <= '0;
            olen_reg <= '0;
            last_reg <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            if (taken)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && !fin_reg)
                    begin
                        // single-word answer by default
                        ov_reg <= 1'b1;
                        last_reg <= 1'b1;
                        aseq_reg <= seq_num;
                        ohdl_reg <= '0;
                        olen_reg <= '0;
                        kind_reg <= srrw_pkg::K_NACK;
                        drain_reg <= 1'b0;
                        if (!crc_ok)
                            kind_reg <= srrw_pkg::K_NACK;
                        else if (opcode <= srrw_pkg::OP_START)
                        begin
                            if (seq_num > exp_reg)
                                kind_reg <= srrw_pkg::K_NACK;
                            else if (seq_num < exp_reg)
                                kind_reg <= srrw_pkg::K_ACK;
                            else
                            begin
                                case (opcode)
                                    srrw_pkg::OP_NAME:
                                        if (!len_txt_bad)
                                        begin
                                            open_reg <= 1'b1;
                                            kind_reg <= srrw_pkg::K_ACK;
                                            exp_reg <= exp_reg + 32'd1;
                                        end
                                    srrw_pkg::OP_WINDOW:
                                        if (!len_txt_bad && window_request != 16'd0
                                            && window_request <= 16'(srrw_pkg::WINDOW_MAX))
                                        begin
                                            valid_reg <= '0;
                                            win_reg <= WW'(window_request);
                                            kind_reg <= srrw_pkg::K_ACK;
                                            exp_reg <= exp_reg + 32'd1;
                                        end
                                    srrw_pkg::OP_FSIZE:
                                        if (!len_txt_bad)
                                        begin
                                            kind_reg <= srrw_pkg::K_ACK;
                                            exp_reg <= exp_reg + 32'd1;
                                        end
                                    srrw_pkg::OP_HASH:
                                        if (body_len != 10'd0
                                            && body_len < srrw_pkg::HASH_LIMIT)
                                        begin
                                            kind_reg <= srrw_pkg::K_ACK;
                                            exp_reg <= exp_reg + 32'd1;
                                        end
                                    default:
                                    begin
                                        started_reg <= 1'b1;
                                        kind_reg <= srrw_pkg::K_ACK;
                                        exp_reg <= exp_reg + 32'd1;
                                    end
                                endcase
                            end
                        end
                        else if (opcode == srrw_pkg::OP_DATA)
                        begin
                            if (!started_reg || win_reg == '0
                                || body_len < srrw_pkg::OFFSET_BYTES)
                                kind_reg <= srrw_pkg::K_NACK;
                            else if (in_win)
                            begin
                                ov_reg <= 1'b0;
                                state_reg <= S_IDX;
                            end
                            else if (seq_num <= exp_reg)
                                kind_reg <= srrw_pkg::K_ACK;
                            else
                                ov_reg <= 1'b0;
                        end
                        else if (opcode == srrw_pkg::OP_STOP)
                        begin
                            kind_reg <= srrw_pkg::K_ACK;
                            open_reg <= 1'b0;
                            fin_reg <= 1'b1;
                        end
                    end
                end
                S_IDX:
                    if (mrsp.done)
                    begin
                        idx_reg <= mrsp.rem;
                        state_reg <= S_STORE;
                    end
                S_STORE:
                begin
                    valid_reg[idx_reg] <= 1'b1;
                    // the ack word is prepared but not yet sent; last is settled once the drain check is done
                    kind_reg <= srrw_pkg::K_ACK;
                    aseq_reg <= pseq_reg;
                    ohdl_reg <= '0;
                    olen_reg <= '0;
                    drain_reg <= 1'b1;
                    state_reg <= S_DIDX;
                end
                S_DIDX:
                    if (mrsp.done)
                    begin
                        idx_reg <= mrsp.rem;
                        state_reg <= S_DCHK;
                    end
                S_DCHK:
                begin
                    if (hit)
                    begin
                        valid_reg[idx_reg] <= 1'b0;
                        exp_reg <= exp_reg + 32'd1;
                        if (deliver)
                        begin
                            // pending word goes out with last clear
                            ov_reg <= 1'b1;
                            last_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                    else
                    begin
                        ov_reg <= 1'b1;
                        last_reg <= 1'b1;
                        drain_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // the pending word is sent when a deliver follows it or when the drain ends
                    if (!ov_reg || taken)
                    begin
                        if (!drain_reg)
                        begin
                            ov_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            if (kind_reg != srrw_pkg::K_DELIVER && ov_reg == 1'b0
                                && !(rd_len_reg > srrw_pkg::OFFSET_BYTES && open_reg))
                            begin
                                // silent drain: keep the pending word as is
                            end
                            else if (rd_len_reg > srrw_pkg::OFFSET_BYTES && open_reg
                                && (ov_reg || kind_reg != srrw_pkg::K_DELIVER))
                            begin
                                kind_reg <= srrw_pkg::K_DELIVER;
                                aseq_reg <= exp_reg - 32'd1;
                                ohdl_reg <= rd_hdl_reg;
                                olen_reg <= rd_len_reg;
                            end
                            ov_reg <= 1'b0;
                            state_reg <= S_DIDX;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = ov_reg;
    assign kind = kind_reg;
    assign ack_seq = aseq_reg;
    assign out_handle = ohdl_reg;
    assign out_len = olen_reg;
    assign last = last_reg;

    `include "selective_repeat_receive_window_assert.svh"

    `SRRW_ASSERT_IMP(a_no_accept_busy, state_reg != S_IDLE, in_stall)
    `SRRW_ASSERT_IMP(a_deliver_payload, out_valid && kind == srrw_pkg::K_DELIVER, out_len > srrw_pkg::OFFSET_BYTES)
    `SRRW_ASSERT_NXT(a_finished_sticks, fin_reg, fin_reg)
    `SRRW_ASSERT_IMP(a_window_range, 1'b1, win_reg <= WW'(srrw_pkg::WINDOW_MAX))
endmodule

// ----- hw/rtl/srrw_mod.sv -----
// bit-serial remainder of a 32-bit value by the window size
module srrw_mod (
    input  logic clk,
    input  logic rst_n,
    input  srrw_pkg::mod_req_t req,
    output srrw_pkg::mod_rsp_t rsp
);
    logic [31:0] dvd_reg;
    logic [srrw_pkg::WIN_W-1:0] div_reg;
    logic [srrw_pkg::WIN_W:0] rem_reg;
    logic [5:0] cnt_reg;
    logic busy_reg;
    logic done_reg;
    logic [srrw_pkg::WIN_W:0] shifted;
    logic [srrw_pkg::WIN_W:0] rem_next;

    always_comb
    begin
        shifted = {rem_reg[srrw_pkg::WIN_W-1:0], dvd_reg[31]};
        if (shifted >= {1'b0, div_reg})
            rem_next = shifted - {1'b0, div_reg};
        else
            rem_next = shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem = rem_reg[srrw_pkg::SLOT_W-1:0];
endmodule

// ----- dv/selective_repeat_receive_window_tb.sv -----
// testbench for the selective-repeat receive window: directed and random packets checked
// against an in-bench window predictor
module selective_repeat_receive_window_tb;
    // opcode 7 has no name in the package
    localparam logic [2:0] OP_UNKNOWN = 3'd7;
    // generous ceiling on the run, in clock cycles
    localparam int CYCLE_LIMIT = 4000000;
    // quiet cycles after the last answer; covers a full 32-slot drain
    localparam int DRAIN_WAIT = 1500;
    // length of the forced receiver hold-off
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0] kind;
        logic [31:0] seq;
        logic [7:0] handle;
        logic [9:0] len;
        logic last;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] opcode;
    logic [31:0] seq_num;
    logic crc_ok;
    logic [9:0] body_len;
    logic [15:0] window_request;
    logic [7:0] buffer_handle;
    logic out_valid;
    logic out_stall;
    logic [1:0] kind;
    logic [31:0] ack_seq;
    logic [7:0] out_handle;
    logic [9:0] out_len;
    logic last;

    // window predictor state
    logic [31:0] win_expected;
    int win_size;
    bit win_started;
    bit win_file_open;
    bit win_finished;
    bit slot_full [srrw_pkg::WINDOW_MAX];
    logic [31:0] slot_seq_no [srrw_pkg::WINDOW_MAX];
    logic [9:0] slot_bytes [srrw_pkg::WINDOW_MAX];
    logic [7:0] slot_tag [srrw_pkg::WINDOW_MAX];

    answer_t pending_answers[$];
    int mismatches;
    int words_sent;
    int cycles;
    bit no_idle;
    bit hold_req;
    int stall_left;

    selective_repeat_receive_window DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .seq_num(seq_num),
        .crc_ok(crc_ok),
        .body_len(body_len),
        .window_request(window_request),
        .buffer_handle(buffer_handle),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .ack_seq(ack_seq),
        .out_handle(out_handle),
        .out_len(out_len),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle ceiling: a hung block ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // queue one answer of the predictor
    task automatic push_answer(input logic [1:0] k, input logic [31:0] s,
                               input logic [7:0] h, input logic [9:0] l);
        answer_t a;
        a.kind = k;
        a.seq = s;
        a.handle = h;
        a.len = l;
        a.last = 1'b0;
        pending_answers.push_back(a);
    endtask

    // control packets must keep length and window request within the block's limits; start has none
    function automatic bit control_ok(input logic [2:0] op, input logic [9:0] len,
                                      input logic [15:0] req);
        case (op) inside
            srrw_pkg::OP_NAME, srrw_pkg::OP_FSIZE:
                return len != 10'd0 && len < srrw_pkg::TEXT_LIMIT;
            srrw_pkg::OP_WINDOW:
                return len != 10'd0 && len < srrw_pkg::TEXT_LIMIT && req != 16'd0
                    && req <= 16'(srrw_pkg::WINDOW_MAX);
            srrw_pkg::OP_HASH:
                return len != 10'd0 && len < srrw_pkg::HASH_LIMIT;
            default:
                return 1'b1;
        endcase
    endfunction

    // work out the answers one accepted packet causes and update the window state
    task automatic predict_packet(input logic [2:0] op, input logic [31:0] s,
                                  input logic crc, input logic [9:0] len,
                                  input logic [15:0] req, input logic [7:0] h);
        int prior_count;
        int idx;
        prior_count = pending_answers.size();
        if (win_finished)
            return;
        if (!crc)
            push_answer(srrw_pkg::K_NACK, s, 8'd0, 10'd0);
        else if (op <= srrw_pkg::OP_START)
        begin
            if (s > win_expected)
                push_answer(srrw_pkg::K_NACK, s, 8'd0, 10'd0);
            else if (s < win_expected)
                push_answer(srrw_pkg::K_ACK, s, 8'd0, 10'd0);
            else if (!control_ok(op, len, req))
                push_answer(srrw_pkg::K_NACK, s, 8'd0, 10'd0);
            else
            begin
                if (op == srrw_pkg::OP_NAME)
                    win_file_open = 1'b1;
                else if (op == srrw_pkg::OP_WINDOW)
                begin
                    foreach (slot_full[i])
                        slot_full[i] = 1'b0;
                    win_size = int'(req);
                end
                else if (op == srrw_pkg::OP_START)
                    win_started = 1'b1;
                win_expected++;
                push_answer(srrw_pkg::K_ACK, s, 8'd0, 10'd0);
            end
        end
        else if (op == srrw_pkg::OP_DATA)
        begin
            if (!win_started || win_size == 0 || len < srrw_pkg::OFFSET_BYTES)
                push_answer(srrw_pkg::K_NACK, s, 8'd0, 10'd0);
            else if (s >= win_expected && {1'b0, s} < {1'b0, win_expected} + 33'(win_size))
            begin
                idx = int'(s % 32'(win_size));
                if (!slot_full[idx])
                begin
                    slot_full[idx] = 1'b1;
                    slot_seq_no[idx] = s;
                    slot_bytes[idx] = len;
                    slot_tag[idx] = h;
                end
                push_answer(srrw_pkg::K_ACK, s, 8'd0, 10'd0);
                // in-order drain
                idx = int'(win_expected % 32'(win_size));
                while (slot_full[idx] && slot_seq_no[idx] == win_expected)
                begin
                    if (slot_bytes[idx] > srrw_pkg::OFFSET_BYTES && win_file_open)
                        push_answer(srrw_pkg::K_DELIVER, win_expected, slot_tag[idx],
                                    slot_bytes[idx]);
                    slot_full[idx] = 1'b0;
                    win_expected++;
                    idx = int'(win_expected % 32'(win_size));
                end
            end
            else if (s <= win_expected)
                push_answer(srrw_pkg::K_ACK, s, 8'd0, 10'd0);
        end
        else if (op == srrw_pkg::OP_STOP)
        begin
            push_answer(srrw_pkg::K_ACK, s, 8'd0, 10'd0);
            win_file_open = 1'b0;
            win_finished = 1'b1;
        end
        else
            push_answer(srrw_pkg::K_NACK, s, 8'd0, 10'd0);
        if (pending_answers.size() > prior_count)
            pending_answers[pending_answers.size() - 1].last = 1'b1;
    endtask

    // offer one packet header word and wait until the block takes it
    task automatic send_word(input logic [2:0] op, input logic [31:0] s, input logic crc,
                             input logic [9:0] len, input logic [15:0] req,
                             input logic [7:0] h);
        int gap;
        gap = 0;
        if (!no_idle)
            gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode <= op;
        seq_num <= s;
        crc_ok <= crc;
        body_len <= len;
        window_request <= req;
        buffer_handle <= h;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_packet(op, s, crc, len, req, h);
        words_sent++;
    endtask

    // data word with a good header
    task automatic send_data(input logic [31:0] s, input logic [9:0] len,
                             input logic [7:0] h);
        send_word(srrw_pkg::OP_DATA, s, 1'b1, len, 16'd0, h);
    endtask

    // mostly deliverable lengths, some at or under the offset size
    function automatic logic [9:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 10'($urandom_range(0, 3));
        if (r < 12)
            return srrw_pkg::OFFSET_BYTES;
        if (r < 20)
            return 10'd1012;
        return 10'($urandom_range(5, 1012));
    endfunction

    // receiver: random stall, plus one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left > 0)
                stall_left--;
            else if (!no_idle && $urandom_range(0, 9) < 3)
            begin
                out_stall <= 1'b1;
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 40);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // compare each taken answer with the oldest prediction
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d seq %0h handle %0d len %0d last %0b",
                             kind, ack_seq, out_handle, out_len, last);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (want.kind !== kind || want.seq !== ack_seq || want.handle !== out_handle
                    || want.len !== out_len || want.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected kind %0d seq %0h handle %0d len %0d last %0b",
                                 want.kind, want.seq, want.handle, want.len, want.last);
                        $display("          got kind %0d seq %0h handle %0d len %0d last %0b",
                                 kind, ack_seq, out_handle, out_len, last);
                    end
                end
            end
        end
    end

    // header checks, window setup, data edges and silent drains
    task automatic test_directed();
        send_data(32'd0, 10'd20, 8'd1);                                  // data before start
        send_word(srrw_pkg::OP_NAME, 32'd0, 1'b0, 10'd5, 16'd0, 8'd0);   // bad crc
        send_word(OP_UNKNOWN, 32'd0, 1'b1, 10'd5, 16'd0, 8'd0);
        send_word(srrw_pkg::OP_NAME, 32'd0, 1'b1, 10'd0, 16'd0, 8'd0);   // empty name
        send_word(srrw_pkg::OP_NAME, 32'd0, 1'b1, 10'd256, 16'd0, 8'd0); // name too long
        send_word(srrw_pkg::OP_FSIZE, 32'd5, 1'b1, 10'd8, 16'd0, 8'd0);  // ahead of expected
        send_word(srrw_pkg::OP_WINDOW, 32'd0, 1'b1, 10'd10, 16'd0, 8'd0); // zero window
        send_word(srrw_pkg::OP_WINDOW, 32'd0, 1'b1, 10'd10, 16'd33, 8'd0);
        send_word(srrw_pkg::OP_WINDOW, 32'd0, 1'b1, 10'd10, 16'hFFFF, 8'd0);
        send_word(srrw_pkg::OP_WINDOW, 32'd0, 1'b1, 10'd255, 16'd32, 8'd0);
        send_word(srrw_pkg::OP_NAME, 32'd0, 1'b1, 10'd5, 16'd0, 8'd0);   // behind expected
        send_word(srrw_pkg::OP_START, 32'd1, 1'b1, 10'd0, 16'd0, 8'd0);  // no length check
        send_data(32'd2, 10'd20, 8'd7);                                  // no file: silent drain
        send_word(srrw_pkg::OP_NAME, 32'd3, 1'b1, 10'd1, 16'd0, 8'd0);
        send_word(srrw_pkg::OP_FSIZE, 32'd4, 1'b1, 10'd255, 16'd0, 8'd0);
        send_word(srrw_pkg::OP_HASH, 32'd5, 1'b1, 10'd128, 16'd0, 8'd0); // hash too long
        send_word(srrw_pkg::OP_HASH, 32'd5, 1'b1, 10'd127, 16'd0, 8'd0);
        send_data(32'd6, 10'd3, 8'd0);                                   // shorter than offset
        send_data(32'd38, 10'd40, 8'd0);                                 // above window
        send_data(32'd8, 10'd1012, 8'd255);
        send_data(32'd8, 10'd50, 8'd1);                                  // duplicate keeps slot
        send_data(32'd7, srrw_pkg::OFFSET_BYTES, 8'd9);                  // offset only
        send_data(32'd2, 10'd30, 8'd3);                                  // below window
        send_data(32'hFFFF_FFFF, 10'd30, 8'd3);
    endtask

    // random window changes, shuffled in-window bursts and header noise
    task automatic test_random_traffic(input int count);
        int r;
        int k;
        logic [31:0] order[$];
        logic [31:0] tmp;
        int j;
        logic [2:0] op;
        while (words_sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r == 0)
                no_idle = !no_idle;
            if (r < 8)
                send_word(srrw_pkg::OP_WINDOW, win_expected, 1'b1, 10'($urandom_range(1, 255)),
                          (r < 2) ? 16'd1 : (r < 4) ? 16'd32 : 16'($urandom_range(1, 32)),
                          8'($urandom));
            else if (r < 22)
            begin
                op = 3'($urandom_range(0, 7));
                if (op == srrw_pkg::OP_STOP)
                    op = OP_UNKNOWN;
                send_word(op, ($urandom_range(0, 1) ? $urandom
                                                    : win_expected + $urandom_range(0, 3) - 1),
                          ($urandom_range(0, 3) != 0), 10'($urandom_range(0, 1012)),
                          16'($urandom), 8'($urandom));
            end
            else
            begin
                k = $urandom_range(1, win_size);
                order.delete();
                for (int i = 0; i < k; i++)
                    order.push_back(win_expected + 32'(i));
                for (int i = k - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                foreach (order[i])
                begin
                    send_data(order[i], pick_len(), 8'($urandom));
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        send_data(order[i], pick_len(), 8'($urandom));  // repeat
                    else if (r == 1)
                        send_data(win_expected - 32'd1, pick_len(), 8'($urandom));
                    else if (r == 2)
                        send_data(win_expected + 32'(win_size) + $urandom_range(0, 5), 10'd40,
                                  8'($urandom));
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while a full window streams in, so the input stalls
    task automatic test_backpressure();
        logic [31:0] base;
        send_word(srrw_pkg::OP_WINDOW, win_expected, 1'b1, 10'd4, 16'd32, 8'd0);
        hold_req = 1'b1;
        no_idle = 1'b1;
        base = win_expected;
        for (int i = 31; i >= 0; i--)
            send_data(base + 32'(i), 10'($urandom_range(5, 1012)), 8'($urandom));
        no_idle = 1'b0;
    endtask

    // stop ends the transfer; later words get no answer
    task automatic test_stop();
        send_word(srrw_pkg::OP_STOP, $urandom, 1'b1, 10'($urandom_range(0, 1012)),
                  16'($urandom), 8'($urandom));
        send_data(win_expected, 10'd20, 8'd5);
        send_word(srrw_pkg::OP_NAME, win_expected, 1'b1, 10'd5, 16'd0, 8'd0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= srrw_pkg::OP_NAME;
        seq_num <= '0;
        crc_ok <= 1'b0;
        body_len <= '0;
        window_request <= '0;
        buffer_handle <= '0;
        cycles = 0;
        mismatches = 0;
        words_sent = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        win_expected = '0;
        win_size = 0;
        win_started = 1'b0;
        win_file_open = 1'b0;
        win_finished = 1'b0;
        foreach (slot_full[i])
            slot_full[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(200);
        test_backpressure();
        test_random_traffic(367);
        test_stop();

        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
